// File: hw/rtl/lge_pkg.sv
`default_nettype none

package lge_pkg;

  localparam int unsigned GRID_SIDE = 64;
  localparam int unsigned ROW_AW    = $clog2(GRID_SIDE);
  localparam int unsigned SIDE_W    = $clog2(GRID_SIDE + 1);
  localparam int unsigned CELL_W    = 2;
  localparam int unsigned ROW_BITS  = GRID_SIDE * CELL_W;
  localparam int unsigned CNT_W     = 4;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned COORD_W = 6;
  localparam int unsigned CFG_W   = 7;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [APB_AW-3:0] REG_GRID_SIZE = '0;
  localparam logic [CFG_W-1:0]  GRID_SIZE_RST = 7'd40;

  localparam logic [CELL_W-1:0] CELL_DEAD    = 2'd0;
  localparam logic [CELL_W-1:0] CELL_ALIVE   = 2'd1;
  localparam logic [CELL_W-1:0] CELL_BLOCKED = 2'd2;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEP  = 2'd2;

endpackage

`default_nettype wire

// File: hw/rtl/lge_if.sv
`default_nettype none

interface lge_req_if;
  logic                         valid;
  logic                         ready;
  logic [lge_pkg::MODE_W-1:0]   mode;
  logic [lge_pkg::COORD_W-1:0]  row;
  logic [lge_pkg::COORD_W-1:0]  col;
  logic [lge_pkg::CELL_W-1:0]   cell_value;

  modport source (output valid, mode, row, col, cell_value, input ready);
  modport sink   (input valid, mode, row, col, cell_value, output ready);
endinterface

interface lge_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lge_pkg::CELL_W-1:0]  cell_state;
  logic                        stable;

  modport source (output valid, cell_state, stable, input ready);
  modport sink   (input valid, cell_state, stable, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/life_grid_generation_engine.sv
// Life board engine, B3/S23 with blocked cells, on a 64 x 64 board held as one row
// memory (a row of 2-bit cells per entry, one read and one write port, read data
// registered). Each transfer in gives exactly one transfer out. A cell read or write
// reads its row, and a write then modifies the row and writes it back, before the result
// reaches the output register. A generation streams the board rows through a three-row
// window and writes each new row back in place, one row per cycle, for rows 1 up to
// side - 1, where side is min(grid_size, 64); with side below two it writes none and reports stable.
// One item is worked on at a time. Per-row valid bits, cleared by reset, stand in
// for the all-dead board, so no clearing pass follows reset. grid_size sits at
// byte address 0 and may only be written while the block is idle.

`default_nettype none

module life_grid_generation_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lge_req_if.sink                       req_i,
  lge_rsp_if.source                     rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lge_pkg::APB_AW-1:0]    paddr,
  input  logic [lge_pkg::APB_DW-1:0]    pwdata,
  output logic [lge_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {S_IDLE, S_CELL, S_G_CUR, S_G_ROW, S_PUSH} state_e;

  state_e                              state_q;
  logic [lge_pkg::CFG_W-1:0]           grid_q;
  logic [lge_pkg::MODE_W-1:0]          mode_q;
  logic [lge_pkg::COORD_W-1:0]         row_q;
  logic [lge_pkg::COORD_W-1:0]         col_q;
  logic [lge_pkg::CELL_W-1:0]          val_q;
  logic [lge_pkg::SIDE_W-1:0]          r_q;
  logic [lge_pkg::ROW_BITS-1:0]        above_q;
  logic [lge_pkg::ROW_BITS-1:0]        cur_q;
  logic                                chg_q;
  logic [lge_pkg::CELL_W-1:0]          res_state_q;
  logic                                res_stable_q;
  logic                                out_valid_q;
  logic [lge_pkg::CELL_W-1:0]          out_state_q;
  logic                                out_stable_q;
  logic [lge_pkg::GRID_SIDE-1:0]       row_valid_q;

  logic [lge_pkg::ROW_BITS-1:0]        mem [lge_pkg::GRID_SIDE];
  logic [lge_pkg::ROW_BITS-1:0]        rdata_q;
  logic                                rd_live_q;

  logic [lge_pkg::SIDE_W-1:0]          side;
  logic [lge_pkg::SIDE_W-1:0]          raddr;
  logic                                rd_inrow;
  logic [lge_pkg::ROW_BITS-1:0]        row_data;
  logic                                cell_in;
  logic                                wr_ok;
  logic [lge_pkg::CELL_W-1:0]          cell_rd;
  logic [lge_pkg::ROW_BITS-1:0]        cell_row;
  logic [lge_pkg::ROW_BITS-1:0]        gen_row;
  logic                                row_chg;
  logic                                wr_en;
  logic [lge_pkg::ROW_AW-1:0]          wr_addr;
  logic [lge_pkg::ROW_BITS-1:0]        wr_data;
  logic                                cfg_wr;
  logic                                last_row;

  assign side = (grid_q > lge_pkg::CFG_W'(lge_pkg::GRID_SIDE))
              ? lge_pkg::SIDE_W'(lge_pkg::GRID_SIDE) : lge_pkg::SIDE_W'(grid_q);

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.cell_state = out_state_q;
  assign rsp_o.stable     = out_stable_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
               && (paddr[lge_pkg::APB_AW-1:2] == lge_pkg::REG_GRID_SIZE);
  assign prdata = (paddr[lge_pkg::APB_AW-1:2] == lge_pkg::REG_GRID_SIZE)
                ? lge_pkg::APB_DW'(grid_q) : '0;

  always_comb begin
    case (state_q)
      S_IDLE:  raddr = (req_i.mode == lge_pkg::MODE_STEP) ? lge_pkg::SIDE_W'(1)
                                                          : lge_pkg::SIDE_W'(req_i.row);
      S_G_CUR: raddr = r_q + lge_pkg::SIDE_W'(1);
      S_G_ROW: raddr = r_q + lge_pkg::SIDE_W'(2);
      default: raddr = '0;
    endcase
  end

  assign rd_inrow = (raddr != '0) && (raddr < side);
  assign row_data = rd_live_q ? rdata_q : '0;

  // read port, rows never written read as all dead
  always_ff @(posedge clk_i) begin
    rdata_q   <= mem[raddr[lge_pkg::ROW_AW-1:0]];
    rd_live_q <= row_valid_q[raddr[lge_pkg::ROW_AW-1:0]] && rd_inrow;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign cell_in = (row_q != '0) && (lge_pkg::SIDE_W'(row_q) < side)
                && (col_q != '0) && (lge_pkg::SIDE_W'(col_q) < side);
  assign wr_ok   = (mode_q == lge_pkg::MODE_WRITE) && (val_q <= lge_pkg::CELL_BLOCKED)
                && cell_in;
  assign cell_rd = row_data[{col_q, 1'b0} +: lge_pkg::CELL_W];

  always_comb begin
    cell_row = row_data;
    cell_row[{col_q, 1'b0} +: lge_pkg::CELL_W] = val_q;
  end

  // next generation of the middle window row; cells off the interior keep their value
  always_comb begin
    logic [lge_pkg::GRID_SIDE+1:0] ap, ac, ab;
    logic [lge_pkg::GRID_SIDE-1:0] colm;
    logic [lge_pkg::CNT_W-1:0]     cnt;
    logic [lge_pkg::CELL_W-1:0]    cur, nxt;
    ap      = '0;
    ac      = '0;
    ab      = '0;
    gen_row = cur_q;
    row_chg = 1'b0;
    for (int c = 0; c < lge_pkg::GRID_SIDE; c++) begin
      colm[c]  = (c != 0) && (lge_pkg::SIDE_W'(c) < side);
      ap[c+1]  = colm[c] && (above_q[c*lge_pkg::CELL_W +: lge_pkg::CELL_W] == lge_pkg::CELL_ALIVE);
      ac[c+1]  = colm[c] && (cur_q[c*lge_pkg::CELL_W +: lge_pkg::CELL_W] == lge_pkg::CELL_ALIVE);
      ab[c+1]  = colm[c] && (row_data[c*lge_pkg::CELL_W +: lge_pkg::CELL_W] == lge_pkg::CELL_ALIVE);
    end
    for (int c = 0; c < lge_pkg::GRID_SIDE; c++) begin
      cnt = lge_pkg::CNT_W'(ap[c]) + lge_pkg::CNT_W'(ap[c+1]) + lge_pkg::CNT_W'(ap[c+2])
          + lge_pkg::CNT_W'(ac[c]) + lge_pkg::CNT_W'(ac[c+2])
          + lge_pkg::CNT_W'(ab[c]) + lge_pkg::CNT_W'(ab[c+1]) + lge_pkg::CNT_W'(ab[c+2]);
      cur = cur_q[c*lge_pkg::CELL_W +: lge_pkg::CELL_W];
      case (cur)
        lge_pkg::CELL_ALIVE: begin
          nxt = (cnt == 4'd2 || cnt == 4'd3) ? lge_pkg::CELL_ALIVE : lge_pkg::CELL_DEAD;
        end
        lge_pkg::CELL_BLOCKED: begin
          nxt = (cnt == 4'd3) ? lge_pkg::CELL_ALIVE : lge_pkg::CELL_BLOCKED;
        end
        default: begin
          nxt = (cnt == 4'd3) ? lge_pkg::CELL_ALIVE : lge_pkg::CELL_DEAD;
        end
      endcase
      if (colm[c]) begin
        gen_row[c*lge_pkg::CELL_W +: lge_pkg::CELL_W] = nxt;
        row_chg = row_chg || (nxt != cur);
      end
    end
  end

  assign wr_en    = ((state_q == S_CELL) && wr_ok) || (state_q == S_G_ROW);
  assign wr_addr  = (state_q == S_G_ROW) ? r_q[lge_pkg::ROW_AW-1:0] : row_q;
  assign wr_data  = (state_q == S_G_ROW) ? gen_row : cell_row;
  assign last_row = ((r_q + lge_pkg::SIDE_W'(1)) == side);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      grid_q       <= lge_pkg::GRID_SIZE_RST;
      mode_q       <= '0;
      row_q        <= '0;
      col_q        <= '0;
      val_q        <= '0;
      r_q          <= '0;
      above_q      <= '0;
      cur_q        <= '0;
      chg_q        <= 1'b0;
      res_state_q  <= '0;
      res_stable_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_state_q  <= '0;
      out_stable_q <= 1'b0;
      row_valid_q  <= '0;
    end else begin
      if (cfg_wr) begin
        grid_q <= pwdata[lge_pkg::CFG_W-1:0];
      end
      if (wr_en) begin
        row_valid_q[wr_addr] <= 1'b1;
      end
      if (out_valid_q && rsp_o.ready && (state_q != S_PUSH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            mode_q <= req_i.mode;
            row_q  <= req_i.row;
            col_q  <= req_i.col;
            val_q  <= req_i.cell_value;
            case (req_i.mode)
              lge_pkg::MODE_WRITE, lge_pkg::MODE_READ: begin
                state_q <= S_CELL;
              end
              lge_pkg::MODE_STEP: begin
                res_state_q <= lge_pkg::CELL_DEAD;
                if (side < lge_pkg::SIDE_W'(2)) begin
                  res_stable_q <= 1'b1;
                  state_q      <= S_PUSH;
                end else begin
                  r_q     <= lge_pkg::SIDE_W'(1);
                  above_q <= '0;
                  chg_q   <= 1'b0;
                  state_q <= S_G_CUR;
                end
              end
              default: begin
                res_state_q  <= lge_pkg::CELL_DEAD;
                res_stable_q <= 1'b0;
                state_q      <= S_PUSH;
              end
            endcase
          end
        end
        S_CELL: begin
          res_state_q  <= ((mode_q == lge_pkg::MODE_READ) && cell_in) ? cell_rd
                                                                       : lge_pkg::CELL_DEAD;
          res_stable_q <= 1'b0;
          state_q      <= S_PUSH;
        end
        S_G_CUR: begin
          cur_q   <= row_data;
          state_q <= S_G_ROW;
        end
        S_G_ROW: begin
          above_q <= cur_q;
          cur_q   <= row_data;
          chg_q   <= chg_q || row_chg;
          if (last_row) begin
            res_stable_q <= !(chg_q || row_chg);
            state_q      <= S_PUSH;
          end else begin
            r_q <= r_q + lge_pkg::SIDE_W'(1);
          end
        end
        S_PUSH: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_state_q  <= res_state_q;
            out_stable_q <= res_stable_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lge_checker.sv
`default_nettype none

module lge_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [lge_pkg::CELL_W-1:0]  cell_state_i,
  input logic                        stable_i
);

  // one item at a time: a transfer in closes the input until its result is out
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken again straight after a transfer");

  // a stable flag only comes with a generation, which reports no cell
  a_result_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((cell_state_i <= lge_pkg::CELL_BLOCKED)
                     && !(stable_i && (cell_state_i != lge_pkg::CELL_DEAD))))
    else $error("result carries an impossible field combination");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(cell_state_i) && $stable(stable_i)))
    else $error("stalled result changed");

endmodule

bind life_grid_generation_engine lge_checker u_lge_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .cell_state_i (rsp_o.cell_state),
  .stable_i     (rsp_o.stable)
);

`default_nettype wire

// File: test/lge_grid_checker.sv
`timescale 1ns / 100ps

module lge_grid_checker
  import lge_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  lge_req_if                  req_i,
  lge_rsp_if                  rsp_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [APB_AW-1:0]   paddr_i,
  input  logic [APB_DW-1:0]   pwdata_i,
  input  logic                pready_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [CELL_W-1:0] cell_state;
    logic              stable;
  } grid_rsp_t;

  logic [CELL_W-1:0] board_q [0:GRID_SIDE-1][0:GRID_SIDE-1];
  logic [CFG_W-1:0]  grid_size_q;
  grid_rsp_t         expected_q [$];
  int                fails;

  assign fail_count_o = fails;

  function automatic int active_side();
    return (grid_size_q > GRID_SIDE) ? GRID_SIDE : int'(grid_size_q);
  endfunction

  function automatic bit in_interior(int r, int c, int side);
    return r >= 1 && r < side && c >= 1 && c < side;
  endfunction

  function automatic logic [CELL_W-1:0] cell_at(int r, int c, int side);
    if (!in_interior(r, c, side)) return CELL_DEAD;
    return board_q[r][c];
  endfunction

  function automatic int live_around(int r, int c, int side);
    int n;
    n = 0;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if ((dr != 0 || dc != 0) && cell_at(r + dr, c + dc, side) == CELL_ALIVE) n++;
    return n;
  endfunction

  // whole interior updates from the old board; returns 1 when nothing moved
  function automatic logic advance_board(int side);
    logic [CELL_W-1:0] upd [0:GRID_SIDE-1][0:GRID_SIDE-1];
    logic [CELL_W-1:0] nxt;
    bit                changed;
    int                k;
    changed = 1'b0;
    for (int r = 1; r < side; r++) begin
      for (int c = 1; c < side; c++) begin
        k = live_around(r, c, side);
        case (board_q[r][c])
          CELL_ALIVE:   nxt = (k == 2 || k == 3) ? CELL_ALIVE : CELL_DEAD;
          CELL_BLOCKED: nxt = (k == 3) ? CELL_ALIVE : CELL_BLOCKED;
          default:      nxt = (k == 3) ? CELL_ALIVE : CELL_DEAD;
        endcase
        upd[r][c] = nxt;
        if (nxt != board_q[r][c]) changed = 1'b1;
      end
    end
    for (int r = 1; r < side; r++)
      for (int c = 1; c < side; c++)
        board_q[r][c] = upd[r][c];
    return !changed;
  endfunction

  function automatic grid_rsp_t predict_grid(logic [MODE_W-1:0] mode, logic [COORD_W-1:0] row,
                                             logic [COORD_W-1:0] col, logic [CELL_W-1:0] val);
    grid_rsp_t res;
    int        side;
    res  = '0;
    side = active_side();
    case (mode)
      MODE_WRITE: begin
        if (val <= CELL_BLOCKED && in_interior(int'(row), int'(col), side))
          board_q[row][col] = val;
      end
      MODE_READ: begin
        res.cell_state = cell_at(int'(row), int'(col), side);
      end
      MODE_STEP: begin
        res.stable = advance_board(side);
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin
    grid_rsp_t want;
    if (!rst_ni) begin
      for (int r = 0; r < GRID_SIDE; r++)
        for (int c = 0; c < GRID_SIDE; c++)
          board_q[r][c] = CELL_DEAD;
      grid_size_q = GRID_SIZE_RST;
      expected_q.delete();
      fails = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == {REG_GRID_SIZE, 2'b00})
        grid_size_q = pwdata_i[CFG_W-1:0];
      // result transfer is checked before a same-edge request is predicted
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: cell_state %0d stable %0d", rsp_i.cell_state, rsp_i.stable);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (rsp_i.cell_state !== want.cell_state) begin
            $error("cell_state: expected %0d, actual %0d", want.cell_state, rsp_i.cell_state);
            fails++;
          end
          if (rsp_i.stable !== want.stable) begin
            $error("stable: expected %0d, actual %0d", want.stable, rsp_i.stable);
            fails++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        expected_q.push_back(predict_grid(req_i.mode, req_i.row, req_i.col, req_i.cell_value));
    end
    pending_o <= expected_q.size();
  end

endmodule

// File: test/tb_life_grid_generation_engine.sv
`timescale 1ns / 100ps

module tb_life_grid_generation_engine;
  import lge_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;
  localparam logic [CELL_W-1:0] CELL_INVALID = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  int                side_now;
  bit                no_gaps;

  lge_req_if req_ch ();
  lge_rsp_if rsp_ch ();

  life_grid_generation_engine dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lge_grid_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    if (side_now >= 2 && $urandom_range(0, 4) != 0)
      return COORD_W'($urandom_range(1, side_now - 1));
    return COORD_W'($urandom_range(0, GRID_SIDE - 1));
  endfunction

  // called just after a falling edge; returns just after a falling edge, once the item has been taken
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [COORD_W-1:0] row,
                           input logic [COORD_W-1:0] col, input logic [CELL_W-1:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid      = 1'b1;
    req_ch.mode       = mode;
    req_ch.row        = row;
    req_ch.col        = col;
    req_ch.cell_value = val;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_grid_size(input logic [CFG_W-1:0] size);
    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {REG_GRID_SIZE, 2'b00};
    pwdata  = APB_DW'(size);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    side_now = (size > GRID_SIDE) ? GRID_SIDE : int'(size);
  endtask

  task automatic random_items(input int unsigned count);
    int unsigned       pick;
    logic [CELL_W-1:0] val;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        val = ($urandom_range(0, 19) == 0) ? CELL_INVALID : CELL_W'($urandom_range(0, 2));
        send_item(MODE_WRITE, pick_coord(), pick_coord(), val);
      end else if (pick < 75) begin
        send_item(MODE_READ, pick_coord(), pick_coord(), CELL_W'($urandom));
      end else if (pick < 90) begin
        send_item(MODE_STEP, COORD_W'($urandom), COORD_W'($urandom), CELL_W'($urandom));
      end else if (pick < 95) begin
        send_item(MODE_NONE, COORD_W'($urandom), COORD_W'($urandom), CELL_W'($urandom));
      end else begin
        send_item(MODE_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                  CELL_W'($urandom));
      end
    end
  endtask

  // result side back-pressure
  initial begin
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = pick_gap();
      if (stall != 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_ch.ready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_ch.valid      = 1'b0;
    req_ch.mode       = MODE_WRITE;
    req_ch.row        = '0;
    req_ch.col        = '0;
    req_ch.cell_value = CELL_DEAD;
    side_now          = int'(GRID_SIZE_RST);
    no_gaps           = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset board, blinker, blocked cell, ignored writes, edges of the board
    send_item(MODE_READ,  6'd1,  6'd1,  CELL_DEAD);
    send_item(MODE_READ,  6'd63, 6'd63, CELL_DEAD);
    send_item(MODE_WRITE, 6'd5,  6'd4,  CELL_ALIVE);
    send_item(MODE_WRITE, 6'd5,  6'd5,  CELL_ALIVE);
    send_item(MODE_WRITE, 6'd5,  6'd6,  CELL_ALIVE);
    send_item(MODE_WRITE, 6'd20, 6'd20, CELL_BLOCKED);
    send_item(MODE_WRITE, 6'd20, 6'd21, CELL_INVALID);
    send_item(MODE_WRITE, 6'd0,  6'd5,  CELL_ALIVE);
    send_item(MODE_WRITE, 6'd40, 6'd10, CELL_ALIVE);
    send_item(MODE_WRITE, 6'd63, 6'd63, CELL_ALIVE);
    send_item(MODE_WRITE, 6'd39, 6'd39, CELL_ALIVE);
    send_item(MODE_READ,  6'd5,  6'd5,  CELL_DEAD);
    send_item(MODE_READ,  6'd20, 6'd20, CELL_DEAD);
    send_item(MODE_READ,  6'd20, 6'd21, CELL_DEAD);
    send_item(MODE_READ,  6'd40, 6'd10, CELL_DEAD);
    send_item(MODE_STEP,  6'd0,  6'd0,  CELL_DEAD);
    send_item(MODE_READ,  6'd4,  6'd5,  CELL_DEAD);
    send_item(MODE_NONE,  6'd63, 6'd63, CELL_INVALID);
    // three live cells above the blocked one bring it to life
    send_item(MODE_WRITE, 6'd19, 6'd19, CELL_ALIVE);
    send_item(MODE_WRITE, 6'd19, 6'd20, CELL_ALIVE);
    send_item(MODE_WRITE, 6'd19, 6'd21, CELL_ALIVE);
    send_item(MODE_STEP,  6'd0,  6'd0,  CELL_DEAD);
    send_item(MODE_READ,  6'd20, 6'd20, CELL_DEAD);
    send_item(MODE_READ,  6'd39, 6'd39, CELL_DEAD);
    send_item(MODE_STEP,  6'd0,  6'd0,  CELL_DEAD);

    set_grid_size(7'd64);
    no_gaps = 1'b1;
    random_items(18);
    no_gaps = 1'b0;
    send_item(MODE_WRITE, 6'd60, 6'd60, CELL_BLOCKED);

    // shrunken side hides the far cell, growing again brings it back
    set_grid_size(7'd8);
    send_item(MODE_READ, 6'd60, 6'd60, CELL_DEAD);
    random_items(16);
    set_grid_size(7'd127);
    send_item(MODE_READ, 6'd60, 6'd60, CELL_DEAD);
    random_items(10);

    set_grid_size(7'd2);
    send_item(MODE_WRITE, 6'd1, 6'd1, CELL_BLOCKED);
    send_item(MODE_STEP,  6'd0, 6'd0, CELL_DEAD);
    random_items(8);

    set_grid_size(7'd0);
    random_items(6);
    set_grid_size(7'd1);
    random_items(6);

    set_grid_size(7'd5);
    random_items(18);
    set_grid_size(CFG_W'($urandom_range(2, 64)));
    random_items(16);
    set_grid_size(GRID_SIZE_RST);
    random_items(14);

    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: life_grid_generation_engine.f
hw/rtl/lge_pkg.sv
hw/rtl/lge_if.sv
hw/rtl/life_grid_generation_engine.sv
hw/rtl/lge_checker.sv
test/lge_grid_checker.sv
test/tb_life_grid_generation_engine.sv
